@@ rtl/core/swbrm_pkg.sv @@
// Shared types, codes and constants of the sliding-window byte rate meter.
package swbrm_pkg;

    localparam int ACTION_W  = 2;
    localparam int AMOUNT_W  = 16;
    localparam int ELAPSED_W = 16;
    localparam int RATE_W    = 31;
    localparam int WMS_W     = 13;
    localparam int PMS_W     = 17;
    localparam int PBYTES_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [PMS_W-1:0]    MIN_PUSH_MS     = 17'd100;
    localparam logic [RATE_W-1:0]   RATE_MAX        = {RATE_W{1'b1}};
    localparam logic [PBYTES_W-1:0] BYTES_MAX       = {PBYTES_W{1'b1}};
    localparam logic [WMS_W-1:0]    WINDOW_MS_RESET = 13'd5000;

    typedef struct packed {
        logic [PMS_W-1:0]    interval;
        logic [PBYTES_W-1:0] bytes;
    } hist_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHK,
        ST_RETIRE,
        ST_PUSH,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic retire;
        logic push;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic                short_tick;
        logic                need_retire;
        logic                full;
        logic                div_last;
        logic                out_free;
    } dp_status_t;

endpackage

@@ rtl/core/swbrm_ctrl.sv @@
// Controller state machine of the byte rate meter.
module swbrm_ctrl
    import swbrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.act == ACT_TICK && !sts.short_tick)
                begin
                    state_next = ST_CHK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            // head entry read is registered during this cycle
            ST_CHK:
            begin
                if (sts.need_retire || sts.full)
                begin
                    state_next = ST_RETIRE;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_RETIRE:
            begin
                cmd.retire = 1'b1;
                state_next = ST_CHK;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.div_fin = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/swbrm_dp.sv @@
// Datapath of the byte rate meter: pending sums, history ring, divider, output register.
module swbrm_dp
    import swbrm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [WMS_W-1:0]     cfg_wr_data,
    input  logic [ACTION_W-1:0]  action,
    input  logic [AMOUNT_W-1:0]  amount,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [RATE_W-1:0]    byte_rate,
    output logic                 window_updated,
    input  dp_cmd_t              cmd,
    output dp_status_t           sts
);

    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int WT_W   = PMS_W + PTR_W;
    localparam int WB_W   = PBYTES_W + PTR_W;
    localparam int NUM_W  = WB_W + 10;
    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [PTR_W:0]    DEPTH_P = (PTR_W + 1)'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(HISTORY_DEPTH);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

    hist_entry_t hist_mem [HISTORY_DEPTH];
    hist_entry_t rd_reg;

    logic [WMS_W-1:0]    window_ms_reg;
    logic [ACTION_W-1:0] act_reg;
    logic [PMS_W-1:0]    pending_ms_reg;
    logic [PBYTES_W-1:0] pending_bytes_reg;
    logic [PTR_W-1:0]    head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [WT_W-1:0]     window_time_reg;
    logic [WB_W-1:0]     window_bytes_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic                upd_reg;
    logic                out_valid_reg;
    logic [RATE_W-1:0]   out_rate_reg;
    logic                out_upd_reg;

    logic [NUM_W-1:0]    num_reg;
    logic [WT_W-1:0]     div_reg;
    logic [WT_W-1:0]     rem_reg;
    logic [RATE_W-1:0]   quo_reg;
    logic                ovf_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [PBYTES_W:0]   bytes_sum;
    logic [PTR_W:0]      tail_sum;
    logic [PTR_W-1:0]    tail;
    logic [PTR_W-1:0]    head_inc;
    logic [WT_W-1:0]     wms_ext;
    logic [NUM_W-1:0]    wb_ext;
    logic [WT_W:0]       trial;
    logic                trial_ge;

    assign bytes_sum = {1'b0, pending_bytes_reg} + (PBYTES_W + 1)'(amount);
    assign tail_sum  = {1'b0, head_reg} + (PTR_W + 1)'(count_reg);
    assign tail      = (tail_sum >= DEPTH_P) ? PTR_W'(tail_sum - DEPTH_P)
                                             : tail_sum[PTR_W-1:0];
    assign head_inc  = (head_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign wms_ext   = WT_W'(window_ms_reg);
    assign wb_ext    = NUM_W'(window_bytes_reg);
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, div_reg};

    assign sts.act         = act_reg;
    assign sts.short_tick  = pending_ms_reg < MIN_PUSH_MS;
    assign sts.need_retire = (window_time_reg > wms_ext) && (count_reg != '0);
    assign sts.full        = count_reg >= DEPTH_C;
    assign sts.div_last    = step_reg == STEP_LAST;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign byte_rate      = out_rate_reg;
    assign window_updated = out_upd_reg;

    // history ring, registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            hist_mem[tail] <= '{interval: pending_ms_reg, bytes: pending_bytes_reg};
        end
        rd_reg <= hist_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg     <= WINDOW_MS_RESET;
            act_reg           <= ACT_COUNT;
            pending_ms_reg    <= '0;
            pending_bytes_reg <= '0;
            head_reg          <= '0;
            count_reg         <= '0;
            window_time_reg   <= '0;
            window_bytes_reg  <= '0;
            rate_reg          <= '0;
            upd_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_ms_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                act_reg <= action;
                upd_reg <= 1'b0;
                unique case (action)
                    ACT_COUNT:
                    begin
                        pending_bytes_reg <= bytes_sum[PBYTES_W] ? BYTES_MAX
                                                                 : bytes_sum[PBYTES_W-1:0];
                    end
                    ACT_TICK:
                    begin
                        pending_ms_reg <= pending_ms_reg + PMS_W'(elapsed);
                    end
                    ACT_CLEAR:
                    begin
                        rate_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.retire)
            begin
                window_time_reg  <= window_time_reg - WT_W'(rd_reg.interval);
                window_bytes_reg <= window_bytes_reg - WB_W'(rd_reg.bytes);
                head_reg         <= head_inc;
                count_reg        <= count_reg - 1'b1;
            end
            if (cmd.push)
            begin
                window_time_reg   <= window_time_reg + WT_W'(pending_ms_reg);
                window_bytes_reg  <= window_bytes_reg + WB_W'(pending_bytes_reg);
                count_reg         <= count_reg + 1'b1;
                pending_ms_reg    <= '0;
                pending_bytes_reg <= '0;
                upd_reg           <= 1'b1;
            end
            if (cmd.div_fin)
            begin
                rate_reg <= ovf_reg ? RATE_MAX : quo_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // restoring divider, one numerator bit a cycle; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            // x1000 = x1024 - x16 - x8
            num_reg  <= (wb_ext << 10) - (wb_ext << 4) - (wb_ext << 3);
            div_reg  <= (window_time_reg < (wms_ext >> 1)) ? wms_ext : window_time_reg;
            rem_reg  <= '0;
            quo_reg  <= '0;
            ovf_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= trial_ge ? WT_W'(trial - {1'b0, div_reg}) : trial[WT_W-1:0];
            quo_reg  <= {quo_reg[RATE_W-2:0], trial_ge};
            ovf_reg  <= ovf_reg | quo_reg[RATE_W-1];
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            out_rate_reg <= rate_reg;
            out_upd_reg  <= upd_reg;
        end
    end

endmodule

@@ rtl/core/sliding_window_byte_rate_meter_unit.sv @@
// Top level of the sliding-window byte rate meter.
// Input channel in_valid/in_ready carries one word: action, amount, elapsed.
//   action count adds amount to the pending byte total (saturating at 32 bits),
//   tick adds elapsed ms; clear zeroes the reported rate.
// Output channel out_valid/out_ready returns one word per input word:
//   byte_rate (bytes per second) and window_updated (tick pushed an entry).
// cfg_wr_en/cfg_wr_data write window_ms; the user must do so only while the meter
//   is idle, since the block itself does not enforce it. Count, clear and short
//   ticks pass from accept through an evaluate state to the final state. A pushing
//   tick loops check/retire over old entries, pushes, then runs the divider,
//   one numerator bit a cycle (48 steps at depth 64), and goes to the final state.
// One word is in flight at a time; in_ready is high only while idle.
// The finished word sits in the output register, so the next word is taken
// while it waits; a stalled receiver holds the block in its final state.
// Reset clears pending sums, the ring pointers, the rate and window_ms to 5000.
// History RAM has no reset; only written entries are ever read.
module sliding_window_byte_rate_meter_unit
    import swbrm_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [WMS_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACTION_W-1:0]  action,
    input  logic [AMOUNT_W-1:0]  amount,
    input  logic [ELAPSED_W-1:0] elapsed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RATE_W-1:0]    byte_rate,
    output logic                 window_updated
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    // sequencing: accept, retire loop, push, divide, deliver
    swbrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // sums, history ring, divider and output register
    swbrm_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .action         (action),
        .amount         (amount),
        .elapsed        (elapsed),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .byte_rate      (byte_rate),
        .window_updated (window_updated),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
